FILE: hw/rtl/ffsa_pkg.sv
// Shared types and constants for the first-fit spectrum allocator
package ffsa_pkg;

    localparam int NUM_LINKS = 64;
    localparam int SLOTS     = 320;
    localparam int MAX_HOPS  = 16;

    localparam int LINK_W  = 6;
    localparam int SLOT_W  = 9;
    localparam int HOP_W   = $clog2(MAX_HOPS + 1);
    localparam int HIDX_W  = (MAX_HOPS > 1) ? $clog2(MAX_HOPS) : 1;
    localparam int WORD_W  = 64;
    localparam int NWORDS  = (SLOTS + WORD_W - 1) / WORD_W;
    localparam int WIDX_W  = (NWORDS > 1) ? $clog2(NWORDS) : 1;
    localparam int MADDR_W = $clog2(NUM_LINKS * NWORDS);

    localparam logic OP_CHECK  = 1'b0;
    localparam logic OP_ASSIGN = 1'b1;

    typedef struct packed {
        logic              opcode;
        logic [LINK_W-1:0] link_index;
        logic [SLOT_W-1:0] slots_needed;
        logic              last_link;
    } ffsa_in_t;

    typedef struct packed {
        logic              found;
        logic [SLOT_W-1:0] start_slot;
    } ffsa_out_t;

    // Controller to datapath commands
    typedef struct packed {
        logic              latch_item;  // capture input item, clear word counter
        logic              rd_word;     // issue map read for current word
        logic              rd_path;     // read addresses the stored path link
        logic              and_word;    // AND returned word into common mask
        logic              store_link;  // append link to path list
        logic              scan_step;   // one slot of the first-fit scan
        logic              wr_word;     // read-modify-write step of assignment
        logic              next_word;   // advance word counter
        logic              next_hop;    // advance hop counter, reset word counter
        logic              clear_req;   // end of request
    } ffsa_cmd_t;

    // Datapath to controller status
    typedef struct packed {
        logic link_ok;     // item's link is stored and used
        logic last;        // item closes its request
        logic last_word;   // word counter on final word
        logic scan_done;   // scan has finished
        logic found;       // a block was found
        logic assign_op;   // last item asked to assign
        logic hops_left;   // more stored hops to write
    } ffsa_sts_t;

endpackage

FILE: hw/rtl/ffsa_datapath.sv
// Datapath: slot map memory, common mask, path list, scanner and marker
module ffsa_datapath
    import ffsa_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  ffsa_in_t  in_item,
    input  ffsa_cmd_t cmd,
    output ffsa_sts_t sts,
    output ffsa_out_t result
);

    logic [WORD_W-1:0] map_mem [NUM_LINKS*NWORDS];
    logic [WORD_W-1:0] rd_data_reg;
    logic              rd_ok_reg;
    logic [NUM_LINKS-1:0] written_reg;

    logic              opcode_reg;
    logic [LINK_W-1:0] link_reg;
    logic [SLOT_W-1:0] need_reg;
    logic              last_reg;

    logic [SLOTS-1:0]  mask_reg;
    logic [LINK_W-1:0] path_reg [MAX_HOPS];
    logic [HOP_W-1:0]  hop_count_reg;
    logic [HOP_W-1:0]  hop_reg;
    logic [WIDX_W-1:0] word_reg;

    logic [SLOT_W:0]   scan_pos_reg;
    logic [SLOT_W:0]   run_reg;
    logic              done_reg;
    logic              found_reg;
    logic [SLOT_W-1:0] start_reg;

    logic [LINK_W-1:0]  cur_link;
    logic [MADDR_W-1:0] addr;
    logic [SLOT_W:0]    run_next;
    logic               link_ok;
    logic [SLOT_W+WIDX_W:0] lo_bit;
    logic [WORD_W-1:0]  set_bits;
    logic [SLOTS-1:0]   mask_next;
    logic [WORD_W-1:0]  rd_clean;

    assign link_ok  = ({1'b0, link_reg} < (LINK_W+1)'(NUM_LINKS)) &&
                      (hop_count_reg < HOP_W'(MAX_HOPS));
    assign cur_link = (cmd.wr_word || cmd.rd_path) ? path_reg[hop_reg[HIDX_W-1:0]]
                                                   : link_reg;
    assign addr     = MADDR_W'(cur_link) * MADDR_W'(NWORDS) + MADDR_W'(word_reg);

    // A link never written since reset reads as all free
    assign rd_clean = rd_ok_reg ? rd_data_reg : '0;

    // Map memory: one word read and one word written per cycle
    always_ff @(posedge clk)
    begin
        if (cmd.rd_word)
        begin
            rd_data_reg <= map_mem[addr];
            rd_ok_reg   <= written_reg[cur_link];
        end
        if (cmd.wr_word)
        begin
            map_mem[addr] <= rd_clean | set_bits;
        end
    end

    // Bits of the chosen block that fall in the current word
    always_comb
    begin
        lo_bit = (SLOT_W+WIDX_W+1)'(word_reg) * (SLOT_W+WIDX_W+1)'(WORD_W);
        for (int b = 0; b < WORD_W; b++)
        begin
            set_bits[b] = ((lo_bit + (SLOT_W+WIDX_W+1)'(b)) >= (SLOT_W+WIDX_W+1)'(start_reg))
                && ((lo_bit + (SLOT_W+WIDX_W+1)'(b)) <
                    (SLOT_W+WIDX_W+1)'(start_reg) + (SLOT_W+WIDX_W+1)'(need_reg))
                && ((lo_bit + (SLOT_W+WIDX_W+1)'(b)) < (SLOT_W+WIDX_W+1)'(SLOTS));
        end
    end

    // Common mask update with the returned word
    always_comb
    begin
        mask_next = mask_reg;
        for (int b = 0; b < WORD_W; b++)
        begin
            if (int'(word_reg) * WORD_W + b < SLOTS)
            begin
                mask_next[int'(word_reg) * WORD_W + b] =
                    mask_reg[int'(word_reg) * WORD_W + b] & ~rd_clean[b];
            end
        end
    end

    assign run_next = mask_reg[scan_pos_reg[SLOT_W-1:0]] ? run_reg + 1'b1 : '0;

    always_ff @(posedge clk)
    begin
        if (cmd.latch_item)
        begin
            opcode_reg <= in_item.opcode;
            link_reg   <= in_item.link_index;
            need_reg   <= in_item.slots_needed;
            last_reg   <= in_item.last_link;
        end
        if (cmd.store_link)
        begin
            path_reg[hop_count_reg[HIDX_W-1:0]] <= link_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mask_reg      <= '1;
            hop_count_reg <= '0;
            hop_reg       <= '0;
            word_reg      <= '0;
            scan_pos_reg  <= '0;
            run_reg       <= '0;
            done_reg      <= 1'b0;
            found_reg     <= 1'b0;
            start_reg     <= '0;
            written_reg   <= '0;
        end
        else
        begin
            if (cmd.latch_item)
            begin
                word_reg     <= '0;
                hop_reg      <= '0;
                scan_pos_reg <= '0;
                run_reg      <= '0;
                found_reg    <= 1'b0;
                start_reg    <= '0;
                // zero or oversize requests finish at once
                done_reg     <= (in_item.slots_needed == '0) ||
                                (in_item.slots_needed > SLOT_W'(SLOTS));
            end
            if (cmd.and_word)
            begin
                mask_reg <= mask_next;
            end
            if (cmd.store_link)
            begin
                hop_count_reg <= hop_count_reg + 1'b1;
                word_reg      <= '0;
            end
            if (cmd.next_word)
            begin
                word_reg <= word_reg + 1'b1;
            end
            if (cmd.next_hop)
            begin
                hop_reg  <= hop_reg + 1'b1;
                word_reg <= '0;
            end
            // every word of a link has been written once its last word is
            if (cmd.wr_word && sts.last_word)
            begin
                written_reg[cur_link] <= 1'b1;
            end
            // First-fit scan, one slot per cycle
            if (cmd.scan_step && !done_reg)
            begin
                run_reg      <= run_next;
                scan_pos_reg <= scan_pos_reg + 1'b1;
                if (run_next == {1'b0, need_reg})
                begin
                    done_reg  <= 1'b1;
                    found_reg <= 1'b1;
                    start_reg <= SLOT_W'(scan_pos_reg + 1'b1 - run_next);
                end
                else if (scan_pos_reg == (SLOT_W+1)'(SLOTS - 1))
                begin
                    done_reg <= 1'b1;
                end
            end
            if (cmd.clear_req)
            begin
                mask_reg      <= '1;
                hop_count_reg <= '0;
            end
        end
    end

    always_comb
    begin
        sts.link_ok   = link_ok;
        sts.last      = last_reg;
        sts.last_word = (word_reg == WIDX_W'(NWORDS - 1));
        sts.scan_done = done_reg;
        sts.found     = found_reg;
        sts.assign_op = (opcode_reg == OP_ASSIGN);
        sts.hops_left = (hop_reg < hop_count_reg);
        result.found      = found_reg;
        result.start_slot = found_reg ? start_reg : '0;
    end

`ifndef SYNTH
    a_hops_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        hop_count_reg <= HOP_W'(MAX_HOPS))
        else $error("hop count overflow");
    a_start_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        found_reg |-> (start_reg < SLOT_W'(SLOTS)))
        else $error("start slot out of range");
    a_clear_mask: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.clear_req |=> (mask_reg == '1) && (hop_count_reg == '0))
        else $error("request not cleared");
`endif

endmodule

FILE: hw/rtl/ffsa_ctrl.sv
// Controller state machine sequencing link, scan and assign phases
module ffsa_ctrl
    import ffsa_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    output logic      in_ready,
    output logic      out_valid,
    input  logic      out_ready,
    input  ffsa_sts_t sts,
    output ffsa_cmd_t cmd
);

    typedef enum logic [2:0] {
        S_IDLE, S_RD, S_AND, S_SCAN, S_WRD, S_WWR, S_OUT
    } state_t;

    state_t state_reg, state_next;
    logic   out_valid_reg, out_valid_next;

    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = out_valid_reg;

    always_comb
    begin
        state_next     = state_reg;
        out_valid_next = out_valid_reg;
        cmd            = '0;
        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.latch_item = 1'b1;
                    state_next     = S_RD;
                end
            end
            S_RD:
            begin
                if (sts.link_ok)
                begin
                    cmd.rd_word = 1'b1;
                    state_next  = S_AND;
                end
                else
                begin
                    state_next = sts.last ? S_SCAN : S_IDLE;
                end
            end
            S_AND:
            begin
                cmd.and_word = 1'b1;
                if (sts.last_word)
                begin
                    cmd.store_link = 1'b1;
                    state_next     = sts.last ? S_SCAN : S_IDLE;
                end
                else
                begin
                    cmd.next_word = 1'b1;
                    state_next    = S_RD;
                end
            end
            S_SCAN:
            begin
                cmd.scan_step = 1'b1;
                if (sts.scan_done)
                begin
                    cmd.scan_step = 1'b0;
                    state_next = (sts.found && sts.assign_op) ? S_WRD : S_OUT;
                end
            end
            S_WRD:
            begin
                if (sts.hops_left)
                begin
                    cmd.rd_word = 1'b1;
                    cmd.rd_path = 1'b1;
                    state_next  = S_WWR;
                end
                else
                begin
                    state_next = S_OUT;
                end
            end
            S_WWR:
            begin
                cmd.wr_word = 1'b1;
                if (sts.last_word)
                begin
                    cmd.next_hop = 1'b1;
                end
                else
                begin
                    cmd.next_word = 1'b1;
                end
                state_next = S_WRD;
            end
            S_OUT:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    out_valid_next = 1'b1;
                    cmd.clear_req  = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

`ifndef SYNTH
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !out_ready) |=> out_valid_reg)
        else $error("result dropped");
    a_one_phase: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0({cmd.rd_word && (state_reg == S_RD), cmd.scan_step, cmd.wr_word}))
        else $error("overlapping phases");
    a_wr_after_rd: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.wr_word |-> $past(state_reg == S_WRD))
        else $error("write without read");
`endif

endmodule

FILE: hw/rtl/first_fit_spectrum_allocator.sv
// Top level of the first-fit spectrum allocator
// Each transfer carries one link of a request's path. A link item is accepted,
// then each map word of the link is read and masked in turn; a link beyond
// MAX_HOPS is not read. The last item then scans one slot per cycle, up to
// SLOTS slots (a zero or oversize request closes at once), an assign reads
// and writes back each word of every stored link, and the request closes by
// loading the result register, waiting while an earlier result is still
// pending. Per-link written flags make the map read as all free after reset.
// Items are handled one at a time; a pending result holds up the close of
// the next request, but not the input of its earlier links.
module first_fit_spectrum_allocator
    import ffsa_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    output logic      in_ready,
    input  ffsa_in_t  in_data,
    output logic      out_valid,
    input  logic      out_ready,
    output ffsa_out_t out_data
);

    ffsa_cmd_t cmd;
    ffsa_sts_t sts;
    ffsa_out_t res;
    ffsa_out_t out_reg;

    ffsa_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .sts       (sts),
        .cmd       (cmd)
    );

    ffsa_datapath u_dp (
        .clk     (clk),
        .rst_n   (rst_n),
        .in_item (in_data),
        .cmd     (cmd),
        .sts     (sts),
        .result  (res)
    );

    // Result register, loaded as the request closes
    always_ff @(posedge clk)
    begin
        if (cmd.clear_req)
        begin
            out_reg <= res;
        end
    end

    assign out_data = out_reg;

endmodule

FILE: sim/first_fit_spectrum_allocator_tb.sv
// Self-checking testbench for the first-fit spectrum allocator
`timescale 1ns / 100ps

module first_fit_spectrum_allocator_tb
    import ffsa_pkg::*;
();

    localparam int TOTAL_ITEMS = 1750;

    logic      clk;
    logic      rst_n;
    logic      in_valid;
    logic      in_ready;
    ffsa_in_t  in_data;
    logic      out_valid;
    logic      out_ready;
    ffsa_out_t out_data;

    first_fit_spectrum_allocator u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

    // Shadow copy of the occupancy maps and the request in progress
    logic [SLOTS-1:0]  occupied [NUM_LINKS];
    logic [SLOTS-1:0]  common_free;
    logic [LINK_W-1:0] route [MAX_HOPS];
    int                route_len;

    ffsa_in_t  link_q [$];
    ffsa_out_t alloc_q [$];
    int        links_sent;
    int        links_driven;
    int        mismatches;
    int        gap_pct;
    int        stall_pct;

    // Fold one link transfer into the request; on the last link, pick the block
    function automatic void allocate_link(ffsa_in_t it);
        ffsa_out_t res;
        int        run;
        int        need;
        res  = '0;
        run  = 0;
        need = it.slots_needed;
        if (route_len < MAX_HOPS)
        begin
            route[route_len] = it.link_index;
            route_len++;
            common_free &= ~occupied[it.link_index];
        end
        if (!it.last_link)
            return;
        if (need >= 1 && need <= SLOTS)
        begin
            for (int s = 0; s < SLOTS; s++)
            begin
                run = common_free[s] ? run + 1 : 0;
                if (run == need)
                begin
                    res.found      = 1'b1;
                    res.start_slot = SLOT_W'(s + 1 - need);
                    break;
                end
            end
        end
        if (res.found && it.opcode == OP_ASSIGN)
            for (int h = 0; h < route_len; h++)
                for (int s = res.start_slot; s < res.start_slot + need; s++)
                    occupied[route[h]][s] = 1'b1;
        alloc_q = {alloc_q, res};
        route_len   = 0;
        common_free = '1;
    endfunction

    // Queue one request: a path of links, fields of the last one decide
    task automatic add_request(input logic op, input int need, input int hops,
                               input int first_link);
        ffsa_in_t it;
        for (int h = 0; h < hops; h++)
        begin
            it.opcode       = (h == hops - 1) ? op : 1'($urandom_range(1));
            it.link_index   = (first_link >= 0) ? LINK_W'(first_link + h)
                                                : LINK_W'($urandom_range(NUM_LINKS - 1));
            it.slots_needed = (h == hops - 1) ? SLOT_W'(need) : SLOT_W'($urandom);
            it.last_link    = (h == hops - 1);
            link_q = {link_q, it};
        end
    endtask

    // Clock
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Reset and stimulus
    initial
    begin
        int need;
        int sel;
        rst_n        = 1'b0;
        in_valid     = 1'b0;
        in_data      = '0;
        out_ready    = 1'b0;
        links_sent   = 0;
        links_driven = 0;
        mismatches   = 0;
        route_len    = 0;
        common_free  = '1;
        for (int l = 0; l < NUM_LINKS; l++)
            occupied[l] = '0;

        // directed: extremes, zero and oversize requests, long and repeated paths
        add_request(OP_CHECK, 1, 1, 0);
        add_request(OP_CHECK, SLOTS, 1, 63);
        add_request(OP_ASSIGN, 0, 1, 5);
        add_request(OP_CHECK, SLOTS + 1, 1, 6);
        add_request(OP_ASSIGN, 511, 1, 63);
        add_request(OP_ASSIGN, 5, 3, 0);
        add_request(OP_CHECK, 1, 2, 1);
        add_request(OP_ASSIGN, SLOTS, 1, 40);
        add_request(OP_CHECK, 1, 1, 40);
        add_request(OP_ASSIGN, 4, 18, 10);
        link_q = {link_q, ffsa_in_t'{OP_ASSIGN, 6'd7, 9'd3, 1'b0}};
        link_q = {link_q, ffsa_in_t'{OP_ASSIGN, 6'd7, 9'd3, 1'b1}};
        add_request(OP_CHECK, 1, 1, 7);

        // random requests, mostly short paths and small blocks
        while (link_q.size() < TOTAL_ITEMS)
        begin
            sel = $urandom_range(99);
            if (sel < 80)      need = $urandom_range(8, 1);
            else if (sel < 90) need = $urandom_range(64, 9);
            else if (sel < 95) need = $urandom_range(SLOTS, 65);
            else if (sel < 97) need = 0;
            else               need = $urandom_range(511, SLOTS + 1);
            add_request(1'($urandom_range(1)), need,
                        ($urandom_range(19) == 0) ? $urandom_range(20, 6)
                                                  : $urandom_range(5, 1), -1);
        end

        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        while (link_q.size() != 0 || alloc_q.size() != 0)
            @(posedge clk);
        repeat (800) @(posedge clk);
        if (mismatches == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

    // Idling profile by phase of the run
    always_comb
    begin
        if (links_sent < TOTAL_ITEMS / 3)
        begin
            gap_pct   = 27;
            stall_pct = 61;
        end
        else if (links_sent < 2 * TOTAL_ITEMS / 3)
        begin
            gap_pct   = 61;
            stall_pct = 27;
        end
        else
        begin
            gap_pct   = 0;
            stall_pct = 0;
        end
    end

    // Driver: present the next link at the falling edge once the last one went
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (!in_valid || links_sent == links_driven)
            begin
                if (link_q.size() > 0 && $urandom_range(99) >= gap_pct)
                begin
                    in_data      <= link_q[0];
                    in_valid     <= 1'b1;
                    links_driven <= links_sent + 1;
                end
                else
                begin
                    in_valid <= 1'b0;
                end
            end
            out_ready <= ($urandom_range(99) >= stall_pct);
        end
    end

    // Input transfer: update the prediction and retire the queued link
    always @(posedge clk)
    begin
        if (rst_n && in_valid && in_ready)
        begin
            allocate_link(in_data);
            void'(link_q.pop_front());
            links_sent++;
        end
    end

    // Monitor: compare each result transfer with the oldest prediction
    always @(posedge clk)
    begin
        ffsa_out_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (alloc_q.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result found=%0b start=%0d",
                             out_data.found, out_data.start_slot);
            end
            else
            begin
                want = alloc_q.pop_front();
                if (out_data.found !== want.found || out_data.start_slot !== want.start_slot)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: found %0b/%0b start %0d/%0d (exp/act)",
                                 want.found, out_data.found,
                                 want.start_slot, out_data.start_slot);
                end
            end
        end
    end

    // Watchdog
    initial
    begin
        #50ms;
        $display("FAIL");
        $finish;
    end

endmodule

FILE: files.f
hw/rtl/ffsa_pkg.sv
hw/rtl/ffsa_datapath.sv
hw/rtl/ffsa_ctrl.sv
hw/rtl/first_fit_spectrum_allocator.sv
sim/first_fit_spectrum_allocator_tb.sv
